FILE: hdl/hrhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhq_pkg
// Shared types and constants for the half-grid quantizer with Hadamard rotation.
// ----------------------------------------------------------------------------
package hrhq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 8;
  localparam int NUM_LANES = 8;

  // 1/sqrt(8) in Q0.16
  localparam int INV_SQRT8_W = 16;
  localparam logic signed [INV_SQRT8_W-1:0] INV_SQRT8 = 16'sd23170;
  localparam int ROUND_SHIFT = 16;

  // register index decoded from paddr[2]
  localparam logic REG_ROTATE_ENABLE = 1'b0;
  localparam int   PADDR_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t elem_0;
    sample_t elem_1;
    sample_t elem_2;
    sample_t elem_3;
    sample_t elem_4;
    sample_t elem_5;
    sample_t elem_6;
    sample_t elem_7;
    logic    batch_end;
  } vec_t;

  typedef struct packed {
    sample_t snap_0;
    sample_t snap_1;
    sample_t snap_2;
    sample_t snap_3;
    sample_t snap_4;
    sample_t snap_5;
    sample_t snap_6;
    sample_t snap_7;
    logic    batch_last;
  } quant_t;

  // stage enables for one lane's adder and multiplier registers
  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } lane_ctl_t;

  // H8 entry (row i, column j) is negative when popcount(i & j) is odd
  function automatic logic h8_neg(input logic [2:0] i, input logic [2:0] j);
    logic [2:0] b;
    b = i & j;
    return b[0] ^ b[1] ^ b[2];
  endfunction

endpackage

FILE: hdl/hadamard_relaxed_halfgrid_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hadamard_relaxed_halfgrid_quantizer
// Snaps eight Q8.8 coordinates to the half grid, optionally inside a
// normalized Hadamard rotation.
// ----------------------------------------------------------------------------
// One vector per clock enters and leaves while quant_ready does not hold the
// pipeline. Each vector passes seven register stages, which hold two passes
// through eight parallel transform lanes (row sum, 16-bit scale multiply,
// round), with the snap step between them and saturation in the output
// register.
// Back-pressure from quant_ready holds the pipeline; empty stages are
// filled, so a stalled output does not block accepting while bubbles exist.
// rotate_enable sits at address 0 of the APB port and is sampled per vector.
module hadamard_relaxed_halfgrid_quantizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vec_valid,
  output logic                          vec_ready,
  input  hrhq_pkg::vec_t                vec,
  output logic                          quant_valid,
  input  logic                          quant_ready,
  output hrhq_pkg::quant_t              quant,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrhq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int W     = hrhq_pkg::SAMPLE_W;
  localparam int L     = hrhq_pkg::NUM_LANES;
  localparam int F     = hrhq_pkg::FRAC_BITS;
  localparam int S_W   = W + 3;      // first transform / snapped width
  localparam int T_W   = S_W + 3;    // second transform width
  localparam int NSTG  = 7;
  localparam logic signed [T_W-1:0] SAT_HI = T_W'((longint'(1) << (W - 1)) - 1);
  localparam logic signed [T_W-1:0] SAT_LO = -SAT_HI - T_W'(1);

  // ---------------- configuration ----------------
  logic rotate_enable;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == hrhq_pkg::REG_ROTATE_ENABLE) begin
      rotate_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == hrhq_pkg::REG_ROTATE_ENABLE) begin
      prdata[0] = rotate_enable;
    end
  end

  // ---------------- helpers ----------------
  function automatic logic signed [S_W-1:0] snap_half(input logic signed [S_W-1:0] v);
    logic [F-2:0]            r;
    logic signed [S_W-1:0]   base;
    logic                    up;
    r    = v[F-2:0];
    base = {v[S_W-1:F-1], {(F-1){1'b0}}};
    // tie at the quarter point goes to the integer neighbor
    up   = (r > (F-1)'(1 << (F - 2))) ||
           ((r == (F-1)'(1 << (F - 2))) && v[F-1]);
    return up ? base + S_W'(1 << (F - 1)) : base;
  endfunction

  function automatic hrhq_pkg::sample_t saturate(input logic signed [T_W-1:0] v);
    logic signed [T_W-1:0] c;
    priority if (v > SAT_HI) c = SAT_HI;
    else if (v < SAT_LO)     c = SAT_LO;
    else                     c = v;
    return c[W-1:0];
  endfunction

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || quant_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vec_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= vec_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------- side data ----------------
  logic [NSTG-2:0] rot;
  logic [NSTG-2:0] last;
  logic signed [W-1:0]   x_in [L];
  logic signed [W-1:0]   x0 [L];
  logic signed [W-1:0]   x1 [L];
  logic signed [W-1:0]   x2 [L];
  logic signed [S_W-1:0] s3 [L];
  logic signed [S_W-1:0] s4 [L];
  logic signed [S_W-1:0] s5 [L];
  logic signed [S_W-1:0] rnd1 [L];
  logic signed [T_W-1:0] rnd2 [L];
  hrhq_pkg::sample_t     y [L];
  logic                  y_last;

  assign x_in[0] = vec.elem_0;
  assign x_in[1] = vec.elem_1;
  assign x_in[2] = vec.elem_2;
  assign x_in[3] = vec.elem_3;
  assign x_in[4] = vec.elem_4;
  assign x_in[5] = vec.elem_5;
  assign x_in[6] = vec.elem_6;
  assign x_in[7] = vec.elem_7;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x0      <= x_in;
      rot[0]  <= rotate_enable;
      last[0] <= vec.batch_end;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (rdy[k]) begin
        rot[k]  <= rot[k-1];
        last[k] <= last[k-1];
      end
    end
    if (rdy[1]) x1 <= x0;
    if (rdy[2]) x2 <= x1;
    if (rdy[3]) begin
      for (int i = 0; i < L; i++) begin
        s3[i] <= snap_half(rot[2] ? rnd1[i] : S_W'(x2[i]));
      end
    end
    if (rdy[4]) s4 <= s3;
    if (rdy[5]) s5 <= s4;
    if (rdy[6]) begin
      for (int i = 0; i < L; i++) begin
        y[i] <= saturate(rot[5] ? rnd2[i] : T_W'(s5[i]));
      end
      y_last <= last[5];
    end
  end

  // ---------------- transform lanes ----------------
  hrhq_pkg::lane_ctl_t ctl_fwd;
  hrhq_pkg::lane_ctl_t ctl_inv;

  assign ctl_fwd = '{sum_en: rdy[1], mul_en: rdy[2]};
  assign ctl_inv = '{sum_en: rdy[4], mul_en: rdy[5]};

  for (genvar g = 0; g < L; g++) begin : g_lane
    hrhq_lane #(.LANE(g), .IN_W(W)) u_fwd (
      .clk (clk),
      .ctl (ctl_fwd),
      .src (x0),
      .rnd (rnd1[g])
    );
    hrhq_lane #(.LANE(g), .IN_W(S_W)) u_inv (
      .clk (clk),
      .ctl (ctl_inv),
      .src (s3),
      .rnd (rnd2[g])
    );
  end

  // ---------------- output ----------------
  assign quant_valid = vld[NSTG-1];

  always_comb begin
    quant.snap_0     = y[0];
    quant.snap_1     = y[1];
    quant.snap_2     = y[2];
    quant.snap_3     = y[3];
    quant.snap_4     = y[4];
    quant.snap_5     = y[5];
    quant.snap_6     = y[6];
    quant.snap_7     = y[7];
    quant.batch_last = y_last;
  end

endmodule

FILE: hdl/hrhq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhq_lane
// One output row of the scaled 8-point Walsh-Hadamard transform: signed row
// sum, multiply by 1/sqrt(8), round to nearest (ties up).
// ----------------------------------------------------------------------------
module hrhq_lane #(
  parameter int LANE = 0,
  parameter int IN_W = 16
) (
  input  logic                    clk,
  input  hrhq_pkg::lane_ctl_t     ctl,
  input  logic signed [IN_W-1:0]  src [hrhq_pkg::NUM_LANES],
  output logic signed [IN_W+2:0]  rnd
);

  localparam int SUM_W  = IN_W + 3;
  localparam int PROD_W = SUM_W + hrhq_pkg::INV_SQRT8_W;
  localparam logic signed [PROD_W-1:0] HALF_LSB =
    PROD_W'(longint'(1) << (hrhq_pkg::ROUND_SHIFT - 1));

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] biased;

  always_comb begin
    sum_next = '0;
    for (int j = 0; j < hrhq_pkg::NUM_LANES; j++) begin
      if (hrhq_pkg::h8_neg(3'(LANE), 3'(j))) begin
        sum_next = sum_next - SUM_W'(src[j]);
      end else begin
        sum_next = sum_next + SUM_W'(src[j]);
      end
    end
  end

  assign prod_next = PROD_W'(sum) * PROD_W'(hrhq_pkg::INV_SQRT8);

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum <= sum_next;
    end
    if (ctl.mul_en) begin
      prod <= prod_next;
    end
  end

  // floor((p + 2^15) / 2^16)
  assign biased = prod + HALF_LSB;
  assign rnd    = biased[PROD_W-1:hrhq_pkg::ROUND_SHIFT];

endmodule

FILE: hdl/hrhq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhq_checker
// Port-level checks for the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module hrhq_checker (
  input logic             clk,
  input logic             rst,
  input logic             vec_ready,
  input logic             quant_valid,
  input logic             quant_ready,
  input hrhq_pkg::quant_t quant,
  input logic             pready
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !quant_valid)
    else $error("result request visible right after reset");

  // with nothing waiting at the output the pipeline can always take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !quant_valid |-> vec_ready)
    else $error("input stalled while output register is empty");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    quant_valid && !quant_ready |=> quant_valid && $stable(quant))
    else $error("stalled result request dropped or changed");

  // register port never inserts wait states
  a_no_wait: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind hadamard_relaxed_halfgrid_quantizer hrhq_checker u_hrhq_checker (
  .clk         (clk),
  .rst         (rst),
  .vec_ready   (vec_ready),
  .quant_valid (quant_valid),
  .quant_ready (quant_ready),
  .quant       (quant),
  .pready      (pready)
);
